FILE: rtl/core/rtb_pkg.sv
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared widths, item codes and controller-to-datapath command type for the
// reload timer bank.
// ----------------------------------------------------------------------------
package rtb_pkg;

    // number of timer channels (1 to 16)
    localparam int CHANNELS = 10;

    // channel index width, at least one bit
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int FUNC_W    = 3;
    localparam int CHAN_W    = 4;
    localparam int COUNT_W   = 16;

    // item kind codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 3'd0,
        FUNC_SET_PER  = 3'd1,
        FUNC_SET_BOTH = 3'd2,
        FUNC_RD_DONE  = 3'd3,
        FUNC_RD_SHIFT = 3'd4
    } t_func;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_SET_PER  = 3'd1,
        OP_SET_BOTH = 3'd2,
        OP_RD_DONE  = 3'd3,
        OP_RD_SHIFT = 3'd4,
        OP_STEP     = 3'd5
    } t_dp_op;

    // command from controller to datapath
    typedef struct packed {
        t_dp_op          op;
        logic            ok;        // channel in range
        logic [CH_W-1:0] idx;       // channel the operation works on
        logic            load_out;  // capture the result word
    } t_dp_cmd;

endpackage

FILE: rtl/core/rtb_if.sv
// ----------------------------------------------------------------------------
// rtb_if
// Valid/ready channels of the reload timer bank: item in, result out.
// ----------------------------------------------------------------------------
interface rtb_in_if;
    logic                          valid;
    logic                          ready;
    logic [rtb_pkg::FUNC_W-1:0]    func;
    logic [rtb_pkg::CHAN_W-1:0]    channel;
    logic [rtb_pkg::COUNT_W-1:0]   period;
    logic [rtb_pkg::COUNT_W-1:0]   shift_point;

    modport source (output valid, func, channel, period, shift_point, input ready);
    modport sink   (input valid, func, channel, period, shift_point, output ready);
endinterface

interface rtb_out_if;
    logic valid;
    logic ready;
    logic flag;

    modport source (output valid, flag, input ready);
    modport sink   (input valid, flag, output ready);
endinterface

FILE: rtl/core/rtb_ctrl.sv
// ----------------------------------------------------------------------------
// rtb_ctrl
// Controller: takes item words, decodes them into datapath commands and
// walks all channels one per cycle on a tick.
// ----------------------------------------------------------------------------
module rtb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [rtb_pkg::FUNC_W-1:0]   i_func,
    input  logic [rtb_pkg::CHAN_W-1:0]   i_channel,
    input  logic                         i_out_ready,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output rtb_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                    r_state, n_state;
    logic [rtb_pkg::CH_W-1:0]  r_walk, n_walk;
    logic                      r_out_valid, n_out_valid;
    logic                      w_accept;
    logic                      w_ok;

    // a new word is taken when idle and the result slot is free or draining
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign w_ok        = ({1'b0, i_channel} < (rtb_pkg::CHAN_W + 1)'(rtb_pkg::CHANNELS));

    // next state and command decode
    always_comb begin
        n_state      = r_state;
        n_walk       = r_walk;
        o_cmd.op       = rtb_pkg::OP_NONE;
        o_cmd.ok       = 1'b0;
        o_cmd.idx      = i_channel[rtb_pkg::CH_W-1:0];
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.ok       = w_ok;
                    o_cmd.load_out = 1'b1;
                    unique case (i_func)
                        rtb_pkg::FUNC_TICK: begin
                            n_state = S_WALK;
                            n_walk  = '0;
                        end
                        rtb_pkg::FUNC_SET_PER:  o_cmd.op = rtb_pkg::OP_SET_PER;
                        rtb_pkg::FUNC_SET_BOTH: o_cmd.op = rtb_pkg::OP_SET_BOTH;
                        rtb_pkg::FUNC_RD_DONE:  o_cmd.op = rtb_pkg::OP_RD_DONE;
                        rtb_pkg::FUNC_RD_SHIFT: o_cmd.op = rtb_pkg::OP_RD_SHIFT;
                        default:                o_cmd.op = rtb_pkg::OP_NONE;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.op  = rtb_pkg::OP_STEP;
                o_cmd.ok  = 1'b1;
                o_cmd.idx = r_walk;
                if (r_walk == rtb_pkg::CH_W'(rtb_pkg::CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_walk = r_walk + rtb_pkg::CH_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result slot occupancy
    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/rtb_dpath.sv
// ----------------------------------------------------------------------------
// rtb_dpath
// Datapath: per-channel period, count, shift point and flags, one channel
// updated or read per cycle, plus the registered result flag.
// ----------------------------------------------------------------------------
module rtb_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtb_pkg::t_dp_cmd              i_cmd,
    input  logic [rtb_pkg::COUNT_W-1:0]   i_period,
    input  logic [rtb_pkg::COUNT_W-1:0]   i_shift_point,
    output logic                          o_flag
);

    logic [rtb_pkg::COUNT_W-1:0] r_reload    [rtb_pkg::CHANNELS];
    logic [rtb_pkg::COUNT_W-1:0] r_count     [rtb_pkg::CHANNELS];
    logic [rtb_pkg::COUNT_W-1:0] r_shift_cmp [rtb_pkg::CHANNELS];
    logic [rtb_pkg::CHANNELS-1:0] r_done_mark;
    logic [rtb_pkg::CHANNELS-1:0] r_shift_mark;
    logic                         r_flag;

    logic [rtb_pkg::COUNT_W-1:0] w_count;
    logic [rtb_pkg::COUNT_W-1:0] w_reload;
    logic [rtb_pkg::COUNT_W-1:0] w_shift_cmp;
    logic                        n_flag;

    // selected channel
    assign w_count     = r_count[i_cmd.idx];
    assign w_reload    = r_reload[i_cmd.idx];
    assign w_shift_cmp = r_shift_cmp[i_cmd.idx];

    // flag read, zero for anything but an in-range read
    assign n_flag = i_cmd.ok &&
                    (((i_cmd.op == rtb_pkg::OP_RD_DONE)  && r_done_mark[i_cmd.idx]) ||
                     ((i_cmd.op == rtb_pkg::OP_RD_SHIFT) && r_shift_mark[i_cmd.idx]));

    // channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < rtb_pkg::CHANNELS; c++) begin
                r_reload[c]    <= '0;
                r_count[c]     <= '0;
                r_shift_cmp[c] <= '0;
            end
            r_done_mark  <= '0;
            r_shift_mark <= '0;
        end else if (i_cmd.ok) begin
            unique case (i_cmd.op)
                rtb_pkg::OP_SET_PER: begin
                    r_reload[i_cmd.idx] <= i_period;
                    r_count[i_cmd.idx]  <= i_period;
                end
                rtb_pkg::OP_SET_BOTH: begin
                    r_reload[i_cmd.idx]    <= i_period;
                    r_count[i_cmd.idx]     <= i_period;
                    r_shift_cmp[i_cmd.idx] <= i_shift_point;
                end
                rtb_pkg::OP_RD_DONE: begin
                    r_done_mark[i_cmd.idx] <= 1'b0;
                end
                rtb_pkg::OP_STEP: begin
                    if (w_count != '0) begin
                        if (w_count == rtb_pkg::COUNT_W'(1)) begin
                            r_done_mark[i_cmd.idx] <= 1'b1;
                        end
                        if (w_count == w_shift_cmp) begin
                            r_shift_mark[i_cmd.idx] <= 1'b1;
                        end
                        r_count[i_cmd.idx] <= w_count - rtb_pkg::COUNT_W'(1);
                    end else begin
                        r_shift_mark[i_cmd.idx] <= 1'b0;
                        r_count[i_cmd.idx]      <= w_reload;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

FILE: rtl/core/reload_timer_bank.sv
// ----------------------------------------------------------------------------
// reload_timer_bank
// Bank of down-counting reload timers with set, tick and flag-read items.
//
//   port      dir  carries
//   i_item    in   func, channel, period, shift_point
//   o_result  out  flag
//
// A set or read word's result is registered and valid in the cycle after it is taken.
// A tick word holds ready low while the controller walks the channels one
// per cycle through the single datapath update port.
// The next word is taken only once the output register is empty or drains in
// the same cycle; a stalled result holds the input off.
// Reset clears all periods, counts, shift points and channel flags, not the result flag.
// ----------------------------------------------------------------------------
module reload_timer_bank (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rtb_in_if.sink    i_item,
    rtb_out_if.source o_result
);

    rtb_pkg::t_dp_cmd w_cmd;

    // controller
    rtb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_func      (i_item.func),
        .i_channel   (i_item.channel),
        .i_out_ready (o_result.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    // datapath
    rtb_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_period      (i_item.period),
        .i_shift_point (i_item.shift_point),
        .o_flag        (o_result.flag)
    );

endmodule

FILE: rtl/core/rtb_checker.sv
// ----------------------------------------------------------------------------
// rtb_checker
// Port-level checks on the reload timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module rtb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic [rtb_pkg::FUNC_W-1:0]  i_func,
    input logic [rtb_pkg::CHAN_W-1:0]  i_channel,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_flag
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_flag))
        else $error("result word dropped or changed while stalled");

    // a tick blocks new words while the channels are walked
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func == rtb_pkg::FUNC_TICK) |=> !i_in_ready)
        else $error("word taken during channel walk");

    // every non-read word yields a zero flag next cycle
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func != rtb_pkg::FUNC_RD_DONE) && (i_func != rtb_pkg::FUNC_RD_SHIFT)
        |=> i_out_valid && !i_flag)
        else $error("non-read word gave a set flag");

    // reads of an absent channel give zero
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && ({1'b0, i_channel} >= (rtb_pkg::CHAN_W + 1)'(rtb_pkg::CHANNELS))
        |=> i_out_valid && !i_flag)
        else $error("absent channel read gave a set flag");

endmodule

bind reload_timer_bank rtb_checker u_rtb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_func      (i_item.func),
    .i_channel   (i_item.channel),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_flag      (o_result.flag)
);
